/* hw/rtl/rhc_pkg.sv */
package rhc_pkg;

    localparam int CHAN_W    = 8;
    localparam int HUE_W     = 9;
    localparam int HUE_REM_W = 17;   // 60 * 6 * 255 fits in 17 bits
    localparam int SAT_REM_W = 16;   // 255 * 255 fits in 16 bits
    localparam int T_W       = 11;   // offset*delta - diff stays below 6*256

    typedef struct packed {
        logic                 valid;
        logic [HUE_REM_W-1:0] hue_rem;
        logic [CHAN_W-1:0]    hue_den;
        logic [HUE_W-1:0]     hue_q;
        logic [SAT_REM_W-1:0] sat_rem;
        logic [CHAN_W-1:0]    sat_den;
        logic [CHAN_W-1:0]    sat_q;
        logic [CHAN_W-1:0]    bright;
    } t_pipe;

endpackage

/* hw/rtl/rhc_prep.sv */
module rhc_prep (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [rhc_pkg::CHAN_W-1:0] i_red,
    input  logic [rhc_pkg::CHAN_W-1:0] i_green,
    input  logic [rhc_pkg::CHAN_W-1:0] i_blue,
    output rhc_pkg::t_pipe             o_pipe
);
    import rhc_pkg::*;

    logic [CHAN_W-1:0]    mx;
    logic [CHAN_W-1:0]    mn;
    logic [CHAN_W-1:0]    delta;
    logic                 grey;
    logic [T_W:0]         t_wide;
    logic [T_W-1:0]       t;
    logic [HUE_REM_W-1:0] hue_num;
    logic [SAT_REM_W-1:0] sat_num;
    t_pipe                n_pipe;
    t_pipe                r_pipe;

    always_comb begin
        mx = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx)  mx = i_blue;
        mn = i_red;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn)  mn = i_blue;
        delta = mx - mn;
        grey  = (mx == mn);

        // sector offset times delta, minus the channel difference
        if (i_red == mn) begin
            t_wide = {3'b000, delta, 1'b0} + {4'b0000, delta}
                   - {4'b0000, i_green} + {4'b0000, i_blue};
        end else if (i_blue == mn) begin
            t_wide = {4'b0000, delta} - {4'b0000, i_red} + {4'b0000, i_green};
        end else begin
            t_wide = {2'b00, delta, 2'b00} + {4'b0000, delta}
                   - {4'b0000, i_blue} + {4'b0000, i_red};
        end
        t = t_wide[T_W-1:0];

        // 60*t and 255*delta by shift and subtract
        hue_num = {t, 6'b0} - {4'b0000, t, 2'b00};
        sat_num = {delta, 8'b0} - {8'b0, delta};

        n_pipe.valid   = i_valid;
        n_pipe.hue_q   = '0;
        n_pipe.sat_q   = '0;
        n_pipe.bright  = mx;
        // grey: zero numerators over unit divisors give zero quotients
        n_pipe.hue_rem = grey ? '0 : hue_num;
        n_pipe.hue_den = grey ? CHAN_W'(1) : delta;
        n_pipe.sat_rem = grey ? '0 : sat_num;
        n_pipe.sat_den = grey ? CHAN_W'(1) : mx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe.valid <= 1'b0;
        end else begin
            r_pipe.valid <= n_pipe.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pipe.hue_rem <= n_pipe.hue_rem;
        r_pipe.hue_den <= n_pipe.hue_den;
        r_pipe.hue_q   <= n_pipe.hue_q;
        r_pipe.sat_rem <= n_pipe.sat_rem;
        r_pipe.sat_den <= n_pipe.sat_den;
        r_pipe.sat_q   <= n_pipe.sat_q;
        r_pipe.bright  <= n_pipe.bright;
    end

    assign o_pipe = r_pipe;

endmodule

/* hw/rtl/rhc_div_stage.sv */
module rhc_div_stage #(
    parameter int HUE_HI    = 8,
    parameter int HUE_STEPS = 3,
    parameter int SAT_HI    = 7,
    parameter int SAT_STEPS = 3
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rhc_pkg::t_pipe i_pipe,
    output rhc_pkg::t_pipe o_pipe
);
    import rhc_pkg::*;

    t_pipe n_pipe;
    t_pipe r_pipe;

    // restoring division, HUE_STEPS hue and SAT_STEPS saturation quotient bits per stage
    always_comb begin
        logic [HUE_REM_W-1:0] hue_sh;
        logic [SAT_REM_W-1:0] sat_sh;
        n_pipe = i_pipe;
        for (int k = 0; k < HUE_STEPS; k++) begin
            hue_sh = HUE_REM_W'(i_pipe.hue_den) << (HUE_HI - k);
            if (n_pipe.hue_rem >= hue_sh) begin
                n_pipe.hue_rem = n_pipe.hue_rem - hue_sh;
                n_pipe.hue_q   = {n_pipe.hue_q[HUE_W-2:0], 1'b1};
            end else begin
                n_pipe.hue_q   = {n_pipe.hue_q[HUE_W-2:0], 1'b0};
            end
        end
        for (int k = 0; k < SAT_STEPS; k++) begin
            sat_sh = SAT_REM_W'(i_pipe.sat_den) << (SAT_HI - k);
            if (n_pipe.sat_rem >= sat_sh) begin
                n_pipe.sat_rem = n_pipe.sat_rem - sat_sh;
                n_pipe.sat_q   = {n_pipe.sat_q[CHAN_W-2:0], 1'b1};
            end else begin
                n_pipe.sat_q   = {n_pipe.sat_q[CHAN_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe.valid <= 1'b0;
        end else begin
            r_pipe.valid <= n_pipe.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pipe.hue_rem <= n_pipe.hue_rem;
        r_pipe.hue_den <= n_pipe.hue_den;
        r_pipe.hue_q   <= n_pipe.hue_q;
        r_pipe.sat_rem <= n_pipe.sat_rem;
        r_pipe.sat_den <= n_pipe.sat_den;
        r_pipe.sat_q   <= n_pipe.sat_q;
        r_pipe.bright  <= n_pipe.bright;
    end

    assign o_pipe = r_pipe;

endmodule

/* hw/rtl/rgb_to_hsv_converter_core.sv */
// throughput: one pixel per cycle, busy is never raised
// the pipe has 4 stages: channel sort and numerators, then
// three stages of restoring division, 3 hue and up to 3 saturation quotient bits each
// reset: synchronous active-low i_rst_n clears the stage valid bits only
// the receiver cannot stall, each result shows for exactly one cycle
module rgb_to_hsv_converter_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [rhc_pkg::CHAN_W-1:0] i_red,
    input  logic [rhc_pkg::CHAN_W-1:0] i_green,
    input  logic [rhc_pkg::CHAN_W-1:0] i_blue,
    output logic                       o_valid,
    output logic [rhc_pkg::HUE_W-1:0]  o_hue,
    output logic [rhc_pkg::CHAN_W-1:0] o_saturation,
    output logic [rhc_pkg::CHAN_W-1:0] o_brightness
);
    import rhc_pkg::*;

    t_pipe s1;
    t_pipe s2;
    t_pipe s3;
    t_pipe s4;

    assign busy = 1'b0;

    rhc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_pipe  (s1)
    );

    rhc_div_stage #(.HUE_HI(8), .HUE_STEPS(3), .SAT_HI(7), .SAT_STEPS(3)) u_div0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pipe  (s1),
        .o_pipe  (s2)
    );

    rhc_div_stage #(.HUE_HI(5), .HUE_STEPS(3), .SAT_HI(4), .SAT_STEPS(3)) u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pipe  (s2),
        .o_pipe  (s3)
    );

    rhc_div_stage #(.HUE_HI(2), .HUE_STEPS(3), .SAT_HI(1), .SAT_STEPS(2)) u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pipe  (s3),
        .o_pipe  (s4)
    );

    assign o_valid      = s4.valid;
    assign o_hue        = s4.hue_q;
    assign o_saturation = s4.sat_q;
    assign o_brightness = s4.bright;

endmodule

/* hw/rtl/rhc_checker.sv */
module rhc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_valid,
    input logic [rhc_pkg::HUE_W-1:0]  o_hue,
    input logic [rhc_pkg::CHAN_W-1:0] o_saturation,
    input logic [rhc_pkg::CHAN_W-1:0] o_brightness
);
    import rhc_pkg::*;

    // every accepted pixel comes out after the prep register and the three division stage registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_valid)
        else $error("accepted pixel gave no result after four cycles");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##4 !o_valid)
        else $error("result strobe without an accepted pixel");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hue < HUE_W'(360)))
        else $error("hue out of range");

    // zero saturation only for grey, which also has zero hue
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_saturation == '0)) |-> (o_hue == '0))
        else $error("zero saturation with nonzero hue");

    a_sat_le_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_brightness == '0)) |-> (o_saturation == '0))
        else $error("black pixel with nonzero saturation");

endmodule

bind rgb_to_hsv_converter_core rhc_checker u_rhc_checker (.*);
